FILE: hw/rtl/rclt_pkg.sv
// Package for the row cache LRU tag unit: field widths, op and status codes,
// and the default slot count. No dependencies.
`default_nettype none

package rclt_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned ROW_W    = 16;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_O_W = 3;

  localparam logic [OP_W-1:0] OP_LOOKUP_IDX = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP_ID  = 2'd1;
  localparam logic [OP_W-1:0] OP_FILL       = 2'd2;

  localparam logic [STATUS_W-1:0] STS_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_RANGE  = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FILLED = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // load the request register from the input beat
    logic commit;   // apply the held request and load the result register
  } rclt_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rclt_ifs.sv
// Valid/ready channel interfaces for requests and results of the row cache
// LRU tag unit. Depends on rclt_pkg.
`default_nettype none

interface rclt_in_if import rclt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ROW_W-1:0]  row_index;
  logic              index_known;
  logic [ID_W-1:0]   entry_id;

  modport source (output valid, op, row_index, index_known, entry_id, input ready);
  modport sink   (input valid, op, row_index, index_known, entry_id, output ready);
endinterface

interface rclt_out_if import rclt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_O_W-1:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rclt_ctrl.sv
// Controller of the row cache LRU tag unit: request-held state, result valid
// and the capture/commit commands. Depends on rclt_pkg.
`default_nettype none

module rclt_ctrl import rclt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rclt_cmd_t      cmd,
  output logic           busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HELD = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  // The result register is free when empty or being drained this cycle.
  assign out_free     = !out_valid_r || out_ready;
  assign cmd.commit   = (state_r == ST_HELD) && out_free;
  assign in_ready     = (state_r == ST_IDLE) || out_free;
  assign cmd.capture  = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign busy         = (state_r == ST_HELD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_HELD;
      end
      ST_HELD: begin
        if (cmd.capture)     state_nxt = ST_HELD;
        else if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.commit)     out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rclt_dpath.sv
// Datapath of the row cache LRU tag unit: request and result registers,
// slot tags and ages, tag compare, victim choice and age update.
// Depends on rclt_pkg.
`default_nettype none

module rclt_dpath import rclt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rclt_cmd_t           cmd,
  input  wire logic                cfg_wr_en,
  input  wire logic [CNT_W-1:0]    cfg_wr_data,
  input  wire logic [OP_W-1:0]     in_op,
  input  wire logic [ROW_W-1:0]    in_row_index,
  input  wire logic                in_index_known,
  input  wire logic [ID_W-1:0]     in_entry_id,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_O_W-1:0]      out_slot
);

  localparam int unsigned SLOT_W  = $clog2(SLOTS);
  localparam int unsigned AGE_W   = SLOT_W;
  localparam int unsigned PRIOR_W = $clog2(SLOTS + 1);

  // Held request.
  logic [OP_W-1:0]  req_op_r;
  logic [ROW_W-1:0] req_row_r;
  logic             req_known_r;
  logic [ID_W-1:0]  req_id_r;

  logic [CNT_W-1:0] catalog_count_r;

  logic [SLOTS-1:0]             slot_valid_r;
  logic [AGE_W-1:0]             slot_age_r [SLOTS];
  logic [ROW_W-1:0]             slot_index_r [SLOTS];
  logic [SLOTS-1:0]             slot_has_index_r;
  logic [ID_W-1:0]              slot_id_r [SLOTS];

  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_O_W-1:0] out_slot_r;

  logic [SLOTS-1:0] idx_match, id_match, fill_cand, oldest;
  logic             idx_found, id_found, cand_found, oldest_found;
  logic [SLOT_W-1:0] idx_enc, id_enc, cand_enc, oldest_enc;
  logic             in_range;

  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   sel;
  logic                touch;
  logic                write_tags;
  logic [PRIOR_W-1:0]  prior;

  // Lowest set bit wins.
  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] pos;
    pos = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) pos = SLOT_W'(i);
    end
    return pos;
  endfunction

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      idx_match[i] = slot_valid_r[i] && slot_has_index_r[i] &&
                     (slot_index_r[i] == req_row_r);
      id_match[i]  = slot_valid_r[i] && (slot_id_r[i] == req_id_r);
      fill_cand[i] = !slot_valid_r[i] || (slot_id_r[i] == req_id_r);
      // Valid ages are always a permutation of 0..n-1, so with every slot
      // valid exactly one slot holds the top age.
      oldest[i]    = slot_valid_r[i] && (slot_age_r[i] == AGE_W'(SLOTS - 1));
    end
  end

  assign idx_found    = |idx_match;
  assign id_found     = |id_match;
  assign cand_found   = |fill_cand;
  assign oldest_found = |oldest;
  assign idx_enc      = first_set(idx_match);
  assign id_enc       = first_set(id_match);
  assign cand_enc     = first_set(fill_cand);
  assign oldest_enc   = first_set(oldest);
  assign in_range     = req_row_r < catalog_count_r;

  always_comb begin
    res_status = STS_MISS;
    sel        = '0;
    touch      = 1'b0;
    write_tags = 1'b0;
    case (req_op_r)
      OP_LOOKUP_IDX: begin
        if (!in_range) begin
          res_status = STS_RANGE;
        end else if (idx_found) begin
          res_status = STS_HIT;
          sel        = idx_enc;
          touch      = 1'b1;
        end
      end
      OP_LOOKUP_ID: begin
        if (id_found) begin
          res_status = STS_HIT;
          sel        = id_enc;
          touch      = 1'b1;
        end
      end
      OP_FILL: begin
        res_status = STS_FILLED;
        touch      = 1'b1;
        write_tags = 1'b1;
        if (cand_found)        sel = cand_enc;
        else if (oldest_found) sel = oldest_enc;
      end
      default: res_status = STS_MISS;
    endcase
    // An empty slot counts as older than all others.
    prior = slot_valid_r[sel] ? PRIOR_W'(slot_age_r[sel]) : PRIOR_W'(SLOTS);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r    <= in_op;
      req_row_r   <= in_row_index;
      req_known_r <= in_index_known;
      req_id_r    <= in_entry_id;
    end
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= SLOT_O_W'(sel);
      if (write_tags) begin
        slot_id_r[sel]        <= req_id_r;
        slot_has_index_r[sel] <= req_known_r;
        slot_index_r[sel]     <= req_known_r ? req_row_r : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      catalog_count_r <= '0;
      slot_valid_r    <= '0;
      for (int i = 0; i < SLOTS; i++) slot_age_r[i] <= '0;
    end else begin
      if (cfg_wr_en) catalog_count_r <= cfg_wr_data;
      if (cmd.commit && touch) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (SLOT_W'(i) == sel) begin
            slot_age_r[i]   <= '0;
            slot_valid_r[i] <= 1'b1;
          end else if (slot_valid_r[i] && (PRIOR_W'(slot_age_r[i]) < prior)) begin
            slot_age_r[i] <= slot_age_r[i] + 1'b1;
          end
        end
      end
    end
  end

  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

endmodule

`default_nettype wire

FILE: hw/rtl/row_cache_lru_tags_unit.sv
// Channel     Dir  Payload                                     Handshake
// in_ch       in   op, row_index, index_known, entry_id        valid/ready
// out_ch      out  status, slot                                valid/ready
// cfg         in   cfg_wr_data (catalog_count)                 cfg_wr_en
//
// Each request beat is captured into the request register, then all slots are
// compared in parallel and the tags, ages and result register update when the
// held request commits. One beat per cycle is sustained while out_ch drains.
// When the result register is full and not taken, the held request waits and
// in_ch stalls. Synchronous reset empties every slot and clears catalog_count.
//
// Top level of the row cache LRU tag unit. Depends on rclt_pkg, rclt_ifs,
// rclt_ctrl and rclt_dpath.
`default_nettype none

module row_cache_lru_tags_unit import rclt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  rclt_in_if.sink               in_ch,
  rclt_out_if.source            out_ch,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data
);

  rclt_cmd_t cmd;
  logic      busy;

  rclt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .busy      (busy)
  );

  rclt_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_op          (in_ch.op),
    .in_row_index   (in_ch.row_index),
    .in_index_known (in_ch.index_known),
    .in_entry_id    (in_ch.entry_id),
    .out_status     (out_ch.status),
    .out_slot       (out_ch.slot)
  );

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("result not presented after commit");

  a_accept_holds_request: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> busy)
    else $error("accepted beat not held");

  a_commit_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> busy)
    else $error("commit without a held request");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == STS_MISS || out_ch.status == STS_RANGE))
      |-> (out_ch.slot == '0))
    else $error("nonzero slot on miss or out of range");

endmodule

`default_nettype wire
